// ===== hdl/mcg_pkg.sv =====
package mcg_pkg;

  localparam int unsigned GridCells = 42;
  localparam int unsigned PosW      = 6;
  localparam int unsigned DayW      = 5;
  localparam int unsigned YearW     = 14;
  localparam int unsigned MonthW    = 4;
  localparam int unsigned WdayW     = 3;
  localparam int unsigned SumW      = 15;
  localparam int unsigned QuotW     = 8;

  localparam logic [PosW-1:0] LastPos = PosW'(GridCells - 1);

  // floor(x / 25) for x below 4096: multiply by ceil(2^17 / 25)
  localparam logic [12:0] Recip25 = 13'd5243;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  // first weekday and length of the month, one word per grid
  typedef struct packed {
    logic [WdayW-1:0] first;
    logic [DayW-1:0]  len;
  } grid_job_t;

  function automatic logic [QuotW-1:0] div25(input logic [11:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'(Recip25);
    return p[24:17];
  endfunction

  // 8 is 1 mod 7, so octal digits fold together
  function automatic logic [WdayW-1:0] mod7(input logic [SumW-1:0] x);
    logic [5:0] s;
    logic [3:0] s2;
    s  = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
    s2 = 4'(s[5:3]) + 4'(s[2:0]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[WdayW-1:0];
  endfunction

  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] l;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    l = 5'd30;
      4'd2:    l = leap ? 5'd29 : 5'd28;
      default: l = 5'd0;
    endcase
    return l;
  endfunction

endpackage

// ===== hdl/mcg_front.sv =====
module mcg_front import mcg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [YearW-1:0]  year_number_i,
  input  logic [MonthW-1:0] month_number_i,
  output logic              push_o,
  output grid_job_t         job_o,
  input  logic              q_ready_i
);

  logic              a_valid_q, b_valid_q, c_valid_q;
  logic              a_ok_q, b_ok_q, c_ok_q;
  logic [YearW-1:0]  a_year_q, a_n_q, b_n_q;
  logic [MonthW-1:0] a_month_q, b_month_q, c_month_q;
  logic [11:0]       b_m_q;
  logic [1:0]        b_ylo_q;
  logic [QuotW-1:0]  b_q100_q, b_q400_q, b_qm_q;
  logic              c_leap_q;
  logic [SumW-1:0]   c_t_q;

  logic              adv;
  logic              in_ok;
  logic              leap;
  logic [SumW-1:0]   t_d;

  assign adv        = !c_valid_q || q_ready_i;
  assign in_ready_o = adv;
  assign in_ok      = (year_number_i != '0) && (month_number_i >= MonthJan)
                      && (month_number_i <= MonthDec);

  // divisible by 4, and not by 100 unless also by 400
  assign leap = (b_ylo_q == 2'd0)
                && ((b_m_q != 12'(b_qm_q) * 12'd25) || (b_qm_q[1:0] == 2'd0));

  assign t_d = SumW'(1) + SumW'(b_n_q) + SumW'(b_n_q[YearW-1:2]) - SumW'(b_q100_q)
               + SumW'(b_q400_q) + SumW'(days_before(b_month_q))
               + SumW'(leap && (b_month_q > MonthFeb));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_ok_q    <= in_ok;
      a_year_q  <= year_number_i;
      a_month_q <= month_number_i;
      a_n_q     <= year_number_i - YearW'(1);

      b_ok_q    <= a_ok_q;
      b_month_q <= a_month_q;
      b_n_q     <= a_n_q;
      b_m_q     <= a_year_q[YearW-1:2];
      b_ylo_q   <= a_year_q[1:0];
      b_q100_q  <= div25(a_n_q[YearW-1:2]);
      b_q400_q  <= div25(12'(a_n_q[YearW-1:4]));
      b_qm_q    <= div25(a_year_q[YearW-1:2]);

      c_ok_q    <= b_ok_q;
      c_month_q <= b_month_q;
      c_leap_q  <= leap;
      c_t_q     <= t_d;
    end
  end

  assign push_o    = c_valid_q && q_ready_i;
  assign job_o.first = c_ok_q ? mod7(c_t_q) : '0;
  assign job_o.len   = c_ok_q ? month_len(c_month_q, c_leap_q) : '0;

endmodule

// ===== hdl/mcg_queue.sv =====
module mcg_queue import mcg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  grid_job_t data_i,
  output logic      ready_o,
  input  logic      pop_i,
  output grid_job_t data_o,
  output logic      valid_o
);

  grid_job_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/mcg_back.sv =====
module mcg_back import mcg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  grid_job_t         q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DayW-1:0]   cell_day_o,
  output logic [PosW-1:0]   cell_position_o,
  output logic              last_cell_o
);

  logic            active_q;
  grid_job_t       cur_q;
  logic [PosW-1:0] pos_q;
  logic            out_valid_q;
  logic [DayW-1:0] day_q;
  logic [PosW-1:0] opos_q;

  logic            load;
  grid_job_t       job;
  logic [PosW-1:0] k;
  logic [PosW-1:0] off;
  logic [DayW-1:0] day_d;

  assign load  = !out_valid_q || out_ready_i;
  assign pop_o = load && !active_q && q_valid_i;
  assign job   = active_q ? cur_q : q_data_i;
  assign k     = active_q ? pos_q : '0;
  assign off   = k - PosW'(job.first);
  assign day_d = ((k >= PosW'(job.first)) && (off < PosW'(job.len)))
                 ? DayW'(off + PosW'(1)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      if (active_q) begin
        out_valid_q <= 1'b1;
        pos_q       <= pos_q + PosW'(1);
        active_q    <= (pos_q != LastPos);
      end else if (q_valid_i) begin
        out_valid_q <= 1'b1;
        pos_q       <= PosW'(1);
        active_q    <= 1'b1;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
    if (load) begin
      day_q  <= day_d;
      opos_q <= k;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cell_day_o      = day_q;
  assign cell_position_o = opos_q;
  assign last_cell_o     = (opos_q == LastPos);

endmodule

// ===== hdl/month_calendar_grid.sv =====
// channel  direction  handshake                 word
// in       input      in_valid_i / in_ready_o   year_number_i, month_number_i
// out      output     out_valid_o / out_ready_i cell_day_o, cell_position_o, last_cell_o
//
// each input word gives 42 output words, one per cycle while out_ready_i is high
// the first cell passes the front stages, the job queue and the output register;
// the back end takes the next word only once its cell counter ends the grid
// front pipeline (3 stages) and a 2-word job queue run ahead of the back end
// rst_ni clears all valid flags and counters at once; no clearing pass
// a stall on out_ready_i holds the output word; the front keeps accepting until
// its queue fills
module month_calendar_grid import mcg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [YearW-1:0]  year_number_i,
  input  logic [MonthW-1:0] month_number_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DayW-1:0]   cell_day_o,
  output logic [PosW-1:0]   cell_position_o,
  output logic              last_cell_o
);

  logic      push, q_ready, q_valid, pop;
  grid_job_t push_data, head;

  mcg_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .year_number_i,
    .month_number_i,
    .push_o    (push),
    .job_o     (push_data),
    .q_ready_i (q_ready)
  );

  mcg_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (push_data),
    .ready_o (q_ready),
    .pop_i   (pop),
    .data_o  (head),
    .valid_o (q_valid)
  );

  mcg_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_data_i  (head),
    .pop_o     (pop),
    .out_valid_o,
    .out_ready_i,
    .cell_day_o,
    .cell_position_o,
    .last_cell_o
  );

endmodule

// ===== hdl/mcg_checker.sv =====
module mcg_checker import mcg_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [DayW-1:0]   cell_day_o,
  input logic [PosW-1:0]   cell_position_o,
  input logic              last_cell_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_day_o)
      && $stable(cell_position_o))
    else $error("output word changed while stalled");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_cell_o == (cell_position_o == LastPos)))
    else $error("last cell flag out of step with position");

  a_next_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_cell_o |=>
      out_valid_o && (cell_position_o == $past(cell_position_o) + PosW'(1)))
    else $error("grid cells not contiguous");

  a_next_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_cell_o && (cell_day_o != '0) |=>
      (cell_day_o == '0) || (cell_day_o == $past(cell_day_o) + DayW'(1)))
    else $error("day numbers not consecutive");

endmodule

bind month_calendar_grid mcg_checker u_mcg_checker (
  .clk_i,
  .rst_ni,
  .out_valid_o,
  .out_ready_i,
  .cell_day_o,
  .cell_position_o,
  .last_cell_o
);

// ===== tb/tb_month_calendar_grid.sv =====
`timescale 1ns / 1ps

module tb_month_calendar_grid;
  import mcg_pkg::*;

  localparam int unsigned RandomRequests = 500;
  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned DrainCycles    = 20;
  localparam int unsigned ReportMax      = 10;

  typedef struct {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
  } request_t;

  typedef struct {
    logic [DayW-1:0] day;
    logic [PosW-1:0] pos;
    logic            last;
  } cell_t;

  typedef enum int unsigned {
    RxFlowing,
    RxRandom,
    RxThrottled
  } rx_mode_e;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [YearW-1:0]  year_number_i  = '0;
  logic [MonthW-1:0] month_number_i = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [DayW-1:0]   cell_day_o;
  logic [PosW-1:0]   cell_position_o;
  logic              last_cell_o;

  request_t    requests_pending[$];
  cell_t       cells_due[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  bit          in_taken   = 1'b0;
  int unsigned burst_left = 4;
  int unsigned gap_left   = 0;
  int unsigned rx_left    = 0;
  rx_mode_e    rx_mode    = RxFlowing;

  const int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  month_calendar_grid dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .year_number_i  (year_number_i),
    .month_number_i (month_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cell_day_o     (cell_day_o),
    .cell_position_o(cell_position_o),
    .last_cell_o    (last_cell_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
    int unsigned d;
    d = month_days[m-1];
    if (leap && m == MonthFeb) begin
      d = d + 1;
    end
    return d;
  endfunction

  // queue the 42 cells of the grid for one year and month
  function automatic void predict_grid(input logic [YearW-1:0] yr,
                                       input logic [MonthW-1:0] mo);
    int unsigned y, m, n, wd, len;
    bit          ok, leap;
    cell_t       c;
    y    = yr;
    m    = mo;
    ok   = (y != 0) && (m >= MonthJan) && (m <= MonthDec);
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    wd   = 0;
    len  = 0;
    if (ok) begin
      n  = y - 1;
      wd = 1 + n + n / 4 - n / 100 + n / 400;
      for (int unsigned i = 1; i < m; i++) begin
        wd = wd + days_in_month(i, leap);
      end
      wd  = wd % 7;
      len = days_in_month(m, leap);
    end
    for (int unsigned k = 0; k < GridCells; k++) begin
      c.day  = (ok && k >= wd && (k - wd) < len) ? DayW'(k - wd + 1) : '0;
      c.pos  = PosW'(k);
      c.last = (k == GridCells - 1);
      cells_due.push_back(c);
    end
  endfunction

  function automatic void add_request(input int unsigned y, input int unsigned m);
    request_t r;
    r.year  = YearW'(y);
    r.month = MonthW'(m);
    requests_pending.push_back(r);
  endfunction

  // sender: bursts of words with random gaps between them
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !in_taken)) begin
      in_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (requests_pending.size() != 0) begin
        year_number_i  <= requests_pending[0].year;
        month_number_i <= requests_pending[0].month;
        void'(requests_pending.pop_front());
        in_valid_i <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                                   : $urandom_range(0, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stretches of full flow, random stalls and heavy throttling
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = $urandom_range(20, 200);
    end
    rx_left = rx_left - 1;
    case (rx_mode)
      RxFlowing:   out_ready_i <= 1'b1;
      RxRandom:    out_ready_i <= 1'($urandom_range(0, 1));
      default:     out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      in_taken = 1'b1;
      predict_grid(year_number_i, month_number_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cells_due.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= ReportMax) begin
          $display("unexpected word: day %0d pos %0d last %0d",
                   cell_day_o, cell_position_o, last_cell_o);
        end
      end else begin
        if (cell_day_o !== cells_due[0].day || cell_position_o !== cells_due[0].pos ||
            last_cell_o !== cells_due[0].last) begin
          mismatches = mismatches + 1;
          if (mismatches <= ReportMax) begin
            $display("mismatch: expected day %0d pos %0d last %0d, got day %0d pos %0d last %0d",
                     cells_due[0].day, cells_due[0].pos, cells_due[0].last,
                     cell_day_o, cell_position_o, last_cell_o);
          end
        end
        void'(cells_due.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int unsigned y, m;
    // edges of the calendar and leap rules
    add_request(1, 1);
    add_request(0, 1);
    add_request(0, 0);
    add_request(2000, 2);
    add_request(1900, 2);
    add_request(2024, 2);
    add_request(2023, 2);
    // months out of range
    add_request(2024, 0);
    add_request(2024, 13);
    add_request(2024, 14);
    add_request(2024, 15);
    // years at and above the top
    add_request(9999, 12);
    add_request(10000, 1);
    add_request(16383, 12);
    add_request(16383, 15);
    add_request(12345, 3);
    for (int unsigned i = 3; i <= 11; i++) begin
      add_request(2025, i);
    end
    for (int unsigned i = 0; i < RandomRequests; i++) begin
      case ($urandom_range(0, 19))
        0:       y = 0;
        1:       y = $urandom_range(10000, 16383);
        default: y = $urandom_range(1, 9999);
      endcase
      m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
      add_request(y, m);
    end

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    while (requests_pending.size() != 0 || in_valid_i || cells_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && cells_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
